>>> design/mmbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbc_pkg
// Shared types, constants and bit-stream helpers of the modular-multiply
// block cipher codec.
// ----------------------------------------------------------------------------
package mmbc_pkg;

    localparam logic [7:0] CHECK_SEED = 8'hF8;
    localparam logic [7:0] SIZE_MASK  = 8'h3D;
    localparam int         NUM_WORDS  = 4;
    localparam int         VAL_BITS   = 18;
    localparam int         BUF_BYTES  = 11;
    localparam logic [3:0] MAX_SIZE   = 4'd8;

    localparam logic [2:0] REG_MODULUS_01  = 3'd0;
    localparam logic [2:0] REG_MODULUS_23  = 3'd1;
    localparam logic [2:0] REG_MULT_KEY_01 = 3'd2;
    localparam logic [2:0] REG_MULT_KEY_23 = 3'd3;
    localparam logic [2:0] REG_XOR_KEY_01  = 3'd4;
    localparam logic [2:0] REG_XOR_KEY_23  = 3'd5;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] data_low;
        logic [23:0] data_high;
        logic [3:0]  plain_size;
    } req_item_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [23:0] result_high;
        logic [3:0]  result_size;
        logic        error;
    } rsp_item_t;

    // Context that travels with an item through the word sections.
    typedef struct packed {
        logic                              kind;
        logic                              bad;
        logic [3:0]                        psize;
        logic [7:0]                        chk;
        logic [7:0]                        t0;
        logic [7:0]                        t1;
        logic [NUM_WORDS-1:0][15:0]        plain;
        logic [NUM_WORDS-1:0][31:0]        vin;
        logic [NUM_WORDS-1:0][31:0]        res;
        logic [15:0]                       prev;
    } word_ctx_t;

    // Reverses the byte order of the 11-byte block, so that the bit stream
    // (byte 0 first, each byte MSB first) reads from the top bit down.
    function automatic logic [87:0] swap_bytes(input logic [87:0] d);
        logic [87:0] r;
        r = '0;
        for (int b = 0; b < BUF_BYTES; b++) begin
            r[87 - 8*b -: 8] = d[8*b +: 8];
        end
        return r;
    endfunction

endpackage

>>> design/mmbc_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbc_word
// One word section: operand select, 32-bit wrapping multiply and a
// pipelined restoring modulo, four quotient bits per stage.
// ----------------------------------------------------------------------------
module mmbc_word (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [1:0]            idx,
    input  logic [31:0]           modulus,
    input  logic [31:0]           mult_key,
    input  logic [31:0]           xor_key,
    input  logic                  ctx_valid,
    input  mmbc_pkg::word_ctx_t   ctx,
    output logic                  done_valid,
    output mmbc_pkg::word_ctx_t   done_ctx
);
    import mmbc_pkg::*;

    localparam int MOD_STAGES = 8;
    localparam int STEP_BITS  = 32 / MOD_STAGES;

    logic [MOD_STAGES:0] vld_reg;
    word_ctx_t           ctx_reg [MOD_STAGES+1];
    logic [31:0]         rem_reg [MOD_STAGES+1];
    logic [31:0]         dvd_reg [MOD_STAGES+1];
    logic [31:0]         operand;
    logic [31:0]         prod;

    always_comb
    begin
        if (ctx.kind == KIND_DECRYPT)
        begin
            operand = ctx.vin[idx];
        end
        else
        begin
            operand = xor_key ^ {16'd0, ctx.plain[idx]} ^ {16'd0, ctx.prev};
        end
        prod = operand * mult_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MOD_STAGES-1:0], ctx_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx;
            rem_reg[0] <= '0;
            dvd_reg[0] <= prod;
        end
    end

    for (genvar k = 1; k <= MOD_STAGES; k++)
    begin : g_mod
        logic [31:0] rem_next;
        logic [31:0] dvd_next;

        always_comb
        begin
            logic [32:0] r;
            rem_next = rem_reg[k-1];
            dvd_next = dvd_reg[k-1];
            for (int s = 0; s < STEP_BITS; s++)
            begin
                r        = {rem_next, dvd_next[31]};
                dvd_next = {dvd_next[30:0], 1'b0};
                if (r >= {1'b0, modulus})
                begin
                    r = r - {1'b0, modulus};
                end
                rem_next = r[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                rem_reg[k] <= rem_next;
                dvd_reg[k] <= dvd_next;
            end
        end
    end

    always_comb
    begin
        done_ctx = ctx_reg[MOD_STAGES];
        if (done_ctx.kind == KIND_DECRYPT)
        begin
            done_ctx.res[idx] = {16'd0, rem_reg[MOD_STAGES][15:0] ^ xor_key[15:0]
                                 ^ done_ctx.prev};
            done_ctx.prev     = done_ctx.vin[idx][15:0];
        end
        else
        begin
            done_ctx.res[idx] = rem_reg[MOD_STAGES];
            done_ctx.prev     = rem_reg[MOD_STAGES][15:0];
        end
    end

    assign done_valid = vld_reg[MOD_STAGES];

endmodule

>>> design/modmul_block_cipher_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modmul_block_cipher_codec_core
// Encrypts or decrypts one 11-byte block per item with four chained
// multiply-and-modulo word sections.
// Pipeline from an accepted item to its result: one decode stage, four word
// sections of nine stages each, one output register.
// Throughput: one item per cycle; every stage advances together unless a
// held result is stalled.
// Reset clears the key registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module modmul_block_cipher_codec_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mmbc_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mmbc_pkg::rsp_item_t  rsp
);
    import mmbc_pkg::*;

    logic [63:0] modulus_01_reg, modulus_23_reg;
    logic [63:0] mult_key_01_reg, mult_key_23_reg;
    logic [63:0] xor_key_01_reg, xor_key_23_reg;

    logic [NUM_WORDS-1:0][31:0] mods, mkeys, xkeys;
    logic                       keys_ok;
    logic                       move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_01_reg  <= '0;
            modulus_23_reg  <= '0;
            mult_key_01_reg <= '0;
            mult_key_23_reg <= '0;
            xor_key_01_reg  <= '0;
            xor_key_23_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS_01:  modulus_01_reg  <= cfg_data;
                REG_MODULUS_23:  modulus_23_reg  <= cfg_data;
                REG_MULT_KEY_01: mult_key_01_reg <= cfg_data;
                REG_MULT_KEY_23: mult_key_23_reg <= cfg_data;
                REG_XOR_KEY_01:  xor_key_01_reg  <= cfg_data;
                REG_XOR_KEY_23:  xor_key_23_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mods  = {modulus_23_reg, modulus_01_reg};
    assign mkeys = {mult_key_23_reg, mult_key_01_reg};
    assign xkeys = {xor_key_23_reg, xor_key_01_reg};

    always_comb
    begin
        keys_ok = 1'b1;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (mods[i] == '0 || mkeys[i] == '0)
            begin
                keys_ok = 1'b0;
            end
        end
    end

    logic rsp_valid_reg;
    rsp_item_t rsp_reg;

    assign move      = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !move;

    // Decode stage.
    word_ctx_t front_next;
    word_ctx_t front_reg;
    logic      front_vld_reg;

    always_comb
    begin
        logic [63:0] padded;
        logic [87:0] seq;
        logic [NUM_WORDS-1:0][31:0] v;
        logic [7:0] c;
        padded = '0;
        c      = CHECK_SEED;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < req.plain_size)
            begin
                padded[8*b +: 8] = req.data_low[8*b +: 8];
            end
            c = c ^ padded[8*b +: 8];
        end
        seq = swap_bytes({req.data_high, req.data_low});
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            v[i] = {14'd0, seq[87 - VAL_BITS*i - 16 -: 2], seq[87 - VAL_BITS*i - 8 -: 8],
                    seq[87 - VAL_BITS*i -: 8]};
        end
        // Undo the neighbor fold from the top word down; the full xor key
        // word reaches the multiplier operand.
        for (int i = NUM_WORDS - 2; i >= 0; i--)
        begin
            v[i] = v[i] ^ xkeys[i] ^ {16'd0, v[i+1][15:0]};
        end
        front_next       = '0;
        front_next.kind  = req.kind;
        front_next.psize = req.plain_size;
        front_next.chk   = c;
        front_next.t0    = seq[15:8];
        front_next.t1    = seq[7:0];
        front_next.plain = padded;
        front_next.vin   = v;
        front_next.bad   = !keys_ok;
        if (req.kind == KIND_ENCRYPT
            && (req.plain_size == 4'd0 || req.plain_size > MAX_SIZE))
        begin
            front_next.bad = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
        end
        else if (move)
        begin
            front_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            front_reg <= front_next;
        end
    end

    // Word sections in a chain.
    logic      sec_vld [NUM_WORDS+1];
    word_ctx_t sec_ctx [NUM_WORDS+1];

    assign sec_vld[0] = front_vld_reg;
    assign sec_ctx[0] = front_reg;

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_word
        mmbc_word u_word (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (move),
            .idx        (2'(i)),
            .modulus    (mods[i]),
            .mult_key   (mkeys[i]),
            .xor_key    (xkeys[i]),
            .ctx_valid  (sec_vld[i]),
            .ctx        (sec_ctx[i]),
            .done_valid (sec_vld[i+1]),
            .done_ctx   (sec_ctx[i+1])
        );
    end

    // Pack, check and register the result.
    rsp_item_t rsp_next;

    always_comb
    begin
        word_ctx_t   x;
        logic [NUM_WORDS-1:0][VAL_BITS-1:0] f;
        logic [87:0] d;
        logic [7:0]  c;
        logic [7:0]  dsize;
        logic [63:0] pl;
        x        = sec_ctx[NUM_WORDS];
        rsp_next = '0;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            f[i]             = x.res[i][VAL_BITS-1:0];
            pl[16*i +: 16]   = x.res[i][15:0];
        end
        for (int i = 0; i < NUM_WORDS - 1; i++)
        begin
            f[i] = f[i] ^ xkeys[i][VAL_BITS-1:0] ^ {2'b00, x.res[i+1][15:0]};
        end
        c = CHECK_SEED;
        for (int b = 0; b < 8; b++)
        begin
            c = c ^ pl[8*b +: 8];
        end
        dsize = x.t0 ^ x.t1 ^ SIZE_MASK;
        d = swap_bytes({f[0][7:0], f[0][15:8], f[0][17:16],
                        f[1][7:0], f[1][15:8], f[1][17:16],
                        f[2][7:0], f[2][15:8], f[2][17:16],
                        f[3][7:0], f[3][15:8], f[3][17:16],
                        x.chk ^ {4'd0, x.psize} ^ SIZE_MASK, x.chk});
        if (x.bad)
        begin
            rsp_next.error = 1'b1;
        end
        else if (x.kind == KIND_ENCRYPT)
        begin
            rsp_next.result_low  = d[63:0];
            rsp_next.result_high = d[87:64];
        end
        else if (c != x.t1 || dsize > {4'd0, MAX_SIZE})
        begin
            rsp_next.error = 1'b1;
        end
        else
        begin
            rsp_next.result_low  = pl;
            rsp_next.result_size = dsize[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            rsp_valid_reg <= sec_vld[NUM_WORDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
